FILE: rtl/core/pllt_pkg.sv
// Shared types and constants for the PLL table best-match search block.
package pllt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FREQ_W      = 32;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = 7;
  localparam int IN_IDX_W    = 6;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // scan counter holds 0..min(count, depth)
  localparam int SCAN_W      = ((IDX_W + 1) > CNT_W) ? (IDX_W + 1) : CNT_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_NONE  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [WORD_W-1:0] word;
  } entry_t;

endpackage

FILE: rtl/core/pllt_if.sv
// Input and result channel interfaces for the PLL table search block.
interface pllt_in_if;
  import pllt_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [IN_IDX_W-1:0] entry_index;
  logic [FREQ_W-1:0]   entry_freq;
  logic [WORD_W-1:0]   entry_word;
  logic [FREQ_W-1:0]   search_freq;

  modport source (output valid, op, entry_index, entry_freq, entry_word, search_freq,
                  input ready);
  modport sink   (input valid, op, entry_index, entry_freq, entry_word, search_freq,
                  output ready);
endinterface

interface pllt_out_if;
  import pllt_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic              exact;
  logic [FREQ_W-1:0] match_freq;
  logic [WORD_W-1:0] match_word;

  modport source (output valid, status, exact, match_freq, match_word, input ready);
  modport sink   (input valid, status, exact, match_freq, match_word, output ready);
endinterface

FILE: rtl/core/pll_table_best_match_search.sv
// PLL setting table with a sequential exact / best-floor frequency search.
//
// Usage:
//   in_ch  : items with op = load (write entry_index <- entry_freq, entry_word)
//            or op = search (look up search_freq). Accepted on valid && ready.
//   out_ch : one result item per search (status, exact, match_freq, match_word).
//   cfg    : cfg_we / cfg_wdata write entry_count, the number of slots searched
//            from slot 0 (clamped to the table depth). Write only while idle.
// Timing:
//   A load item is written on acceptance; in_ready stays high and no result follows.
//   A search walks the table through the single read port, one entry per
//   cycle, with one compare unit; in_ready is low from acceptance until the
//   result moves into the output register: one search in flight at a time.
//   Exact matches win; otherwise the first entry with the largest nonzero
//   frequency not above the target. Not found gives status = 1, zeros elsewhere.
// Reset (rst_n low, synchronous): sequencer idle, output empty, entry_count 0.
//   Table contents are not cleared; slots must be loaded before being searched.
// Stall: a result held in the output register waits for out_ch.ready; the next
//   search finishes its scan and then waits until the register frees up.
module pll_table_best_match_search (
  input  logic              clk,
  input  logic              rst_n,
  pllt_in_if.sink           in_ch,
  pllt_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [pllt_pkg::CNT_W-1:0] cfg_wdata
);
  import pllt_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  entry_count_r;

  // scan sequencer
  logic [SCAN_W-1:0] n_r, n_nxt;
  logic [SCAN_W-1:0] iss_r, iss_nxt;
  logic              dv_r, dv_nxt;
  logic [FREQ_W-1:0] target_r, target_nxt;

  // running pick
  logic              found_r, found_nxt;
  logic              exact_r, exact_nxt;
  logic [FREQ_W-1:0] pick_freq_r, pick_freq_nxt;
  logic [WORD_W-1:0] pick_word_r, pick_word_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r;
  logic              out_exact_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic [WORD_W-1:0] out_word_r;

  // table memory
  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_r;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;

  logic              in_ready;
  logic              accept;
  logic              out_load;
  logic [SCAN_W-1:0] count_ext;
  logic [SCAN_W-1:0] n_clamp;

  localparam logic [SCAN_W-1:0] DEPTH_EXT = SCAN_W'(TABLE_DEPTH);
  localparam logic [31:0]       DEPTH_32  = 32'(TABLE_DEPTH);

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_ch.valid && in_ready;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign count_ext = SCAN_W'(entry_count_r);
  assign n_clamp   = (count_ext > DEPTH_EXT) ? DEPTH_EXT : count_ext;
  assign wr_addr   = IDX_W'(in_ch.entry_index);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.op == OP_SEARCH) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (iss_r == n_r && !dv_r) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    target_nxt    = target_r;
    found_nxt     = found_r;
    exact_nxt     = exact_r;
    pick_freq_nxt = pick_freq_r;
    pick_word_nxt = pick_word_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.op == OP_LOAD) begin
            mem_we = ({{(32-IN_IDX_W){1'b0}}, in_ch.entry_index} < DEPTH_32);
          end else begin
            target_nxt    = in_ch.search_freq;
            n_nxt         = n_clamp;
            iss_nxt       = '0;
            found_nxt     = 1'b0;
            exact_nxt     = 1'b0;
            pick_freq_nxt = '0;
            pick_word_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (iss_r < n_r) begin
          rd_en   = 1'b1;
          iss_nxt = iss_r + SCAN_W'(1);
        end
        // compare unit: exact match freezes the pick
        if (dv_r && !exact_r) begin
          if (rd_r.freq == target_r) begin
            found_nxt     = 1'b1;
            exact_nxt     = 1'b1;
            pick_freq_nxt = rd_r.freq;
            pick_word_nxt = rd_r.word;
          end else if (rd_r.freq <= target_r && rd_r.freq > pick_freq_r) begin
            found_nxt     = 1'b1;
            pick_freq_nxt = rd_r.freq;
            pick_word_nxt = rd_r.word;
          end
        end
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign dv_nxt = rd_en;

  always_comb begin
    if (out_load)                        out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    else                                 out_valid_nxt = out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      dv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) entry_count_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    iss_r       <= iss_nxt;
    target_r    <= target_nxt;
    found_r     <= found_nxt;
    exact_r     <= exact_nxt;
    pick_freq_r <= pick_freq_nxt;
    pick_word_r <= pick_word_nxt;
    if (out_load) begin
      out_status_r <= found_r ? STATUS_FOUND : STATUS_NONE;
      out_exact_r  <= exact_r;
      out_freq_r   <= pick_freq_r;
      out_word_r   <= pick_word_r;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= '{freq: in_ch.entry_freq, word: in_ch.entry_word};
    if (rd_en)  rd_r <= mem[iss_r[IDX_W-1:0]];
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.exact      = out_exact_r;
  assign out_ch.match_freq = out_freq_r;
  assign out_ch.match_word = out_word_r;

endmodule

FILE: rtl/core/pllt_chk.sv
// Port-level assertion checker for the PLL table search block, with its bind.
module pllt_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_status,
  input logic                        out_exact,
  input logic [pllt_pkg::FREQ_W-1:0] out_freq,
  input logic [pllt_pkg::WORD_W-1:0] out_word
);
  import pllt_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_exact)
      && $stable(out_freq) && $stable(out_word))
    else $error("stalled result changed");

  // a search keeps the block busy the cycle after
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_SEARCH |=> !in_ready)
    else $error("ready right after search accepted");

  // not-found carries zeroed fields
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_NONE |-> !out_exact && out_freq == '0
      && out_word == '0)
    else $error("not-found result with nonzero fields");

  // an exact result is always a found result
  a_exact_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exact |-> out_status == STATUS_FOUND)
    else $error("exact flag on not-found result");

endmodule

bind pll_table_best_match_search pllt_chk u_pllt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_exact  (out_ch.exact),
  .out_freq   (out_ch.match_freq),
  .out_word   (out_ch.match_word)
);

FILE: dv/pll_table_best_match_search_test.sv
// Self-checking testbench for the PLL table best-match search block.
module pll_table_best_match_search_test;
  import pllt_pkg::*;

  // Margin, sized from TABLE_DEPTH, for a trailing load or search to finish.
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER = 120;     // results taken before the long stall
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic              status;
    logic              exact;
    logic [FREQ_W-1:0] freq;
    logic [WORD_W-1:0] word;
  } match_t;

  localparam match_t NOT_FOUND = '{STATUS_NONE, 1'b0, '0, '0};

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_SEARCH,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [IN_IDX_W-1:0] idx;
    logic [FREQ_W-1:0]   freq;
    logic [WORD_W-1:0]   word;
    logic [FREQ_W-1:0]   target;
    logic [CNT_W-1:0]    count;
    logic                typed;    // 1: want is the expectation, 0: predictor decides
    match_t              want;
  } stim_row_t;

  // Directed rows: kind, slot, freq, word, target, entry_count, typed, expected.
  // Slots 0..4 after loading: 100, 0, max, 100 (duplicate), 50; slot 0 later
  // becomes 7, so the duplicate in slot 3 takes over the exact hit.
  localparam int DIRECTED_ROWS_N = 25;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_ROWS_N] = '{
    // empty table right after reset: nothing is ever found
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'h0000_0000, 7'd0, 1'b1, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'hFFFF_FFFF, 7'd0, 1'b1, NOT_FOUND},
    '{ROW_LOAD,   6'd0,  32'd100,        32'hFFFF_FFFF, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_LOAD,   6'd1,  32'd0,          32'h0000_0000, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_LOAD,   6'd2,  32'hFFFF_FFFF,  32'hA5A5_5A5A, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_LOAD,   6'd3,  32'd100,        32'h1234_5678, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_LOAD,   6'd4,  32'd50,         32'h8000_0001, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_LOAD,   6'd63, 32'd1,          32'hFFFF_FFFF, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    // one entry searched
    '{ROW_CFG,    6'd0,  32'd0,          32'h0,         32'h0,         7'd1, 1'b0, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd100,       7'd0, 1'b1,
      '{STATUS_FOUND, 1'b1, 32'd100, 32'hFFFF_FFFF}},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd99,        7'd0, 1'b1, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'hFFFF_FFFF, 7'd0, 1'b1,
      '{STATUS_FOUND, 1'b0, 32'd100, 32'hFFFF_FFFF}},
    // five entries: duplicates, a zero entry and the maximum frequency
    '{ROW_CFG,    6'd0,  32'd0,          32'h0,         32'h0,         7'd5, 1'b0, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd100,       7'd0, 1'b1,
      '{STATUS_FOUND, 1'b1, 32'd100, 32'hFFFF_FFFF}},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd0,         7'd0, 1'b1,
      '{STATUS_FOUND, 1'b1, 32'd0, 32'h0000_0000}},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'hFFFF_FFFF, 7'd0, 1'b1,
      '{STATUS_FOUND, 1'b1, 32'hFFFF_FFFF, 32'hA5A5_5A5A}},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd75,        7'd0, 1'b1,
      '{STATUS_FOUND, 1'b0, 32'd50, 32'h8000_0001}},
    // the zero entry never serves as a floor
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd49,        7'd0, 1'b1, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd200,       7'd0, 1'b1,
      '{STATUS_FOUND, 1'b0, 32'd100, 32'hFFFF_FFFF}},
    '{ROW_LOAD,   6'd0,  32'd7,          32'h7FFF_FFFE, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd100,       7'd0, 1'b1,
      '{STATUS_FOUND, 1'b1, 32'd100, 32'h1234_5678}},
    // slot 5 lies past entry_count and must not be picked
    '{ROW_LOAD,   6'd5,  32'hFFFF_FFFE,  32'h0000_0000, 32'h0,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'hFFFF_FFFE, 7'd0, 1'b0, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd8,         7'd0, 1'b0, NOT_FOUND},
    '{ROW_SEARCH, 6'd0,  32'd0,          32'h0,         32'd6,         7'd0, 1'b1, NOT_FOUND}
  };

  // entry_count settings of the random phases; the last two are drawn
  localparam int PHASE_COUNTS [PHASES] = '{64, 127, 1, 65, 0, 2, 100, 64, 33, 127, 0, 0};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  pllt_in_if  in_ch ();
  pllt_out_if out_ch ();

  pll_table_best_match_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the PLL table and the entry_count register, updated as items
  // and writes are accepted.
  logic [FREQ_W-1:0] shadow_freq [TABLE_DEPTH];
  logic [WORD_W-1:0] shadow_word [TABLE_DEPTH];
  logic [CNT_W-1:0]  shadow_count;

  match_t pending_matches [$];   // expected search results, oldest first

  bit calm_phase;                // both sides run without idling
  int unsigned loads_sent, searches_sent, settings_written;
  int unsigned exact_hits, floor_hits, miss_hits;
  int unsigned mismatch_count;
  int unsigned hold_off_done;

  // Exact match first; otherwise the first entry with the largest nonzero
  // frequency at or below the target. Unsigned compares throughout.
  function automatic match_t floor_match_lookup(input logic [FREQ_W-1:0] target);
    match_t            m;
    int                n;
    int                pick;
    bit                hit;
    logic [FREQ_W-1:0] best;
    n    = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    m    = NOT_FOUND;
    hit  = 1'b0;
    pick = 0;
    best = '0;
    for (int i = 0; i < n; i++) begin
      if (!hit && shadow_freq[i] == target) begin
        hit = 1'b1;
        m   = '{STATUS_FOUND, 1'b1, shadow_freq[i], shadow_word[i]};
      end
    end
    if (!hit) begin
      for (int i = 0; i < n; i++) begin
        if (shadow_freq[i] <= target && shadow_freq[i] > best) begin
          best = shadow_freq[i];
          pick = i;
          hit  = 1'b1;
        end
      end
      if (hit) begin
        m = '{STATUS_FOUND, 1'b0, shadow_freq[pick], shadow_word[pick]};
      end
    end
    return m;
  endfunction

  // Frequencies bunch on a coarse grid so that duplicates and exact hits
  // are common; zero and the maximum show up often.
  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return '0;
    if (roll < 12) return '1;
    if (roll < 60) return $urandom_range(1, 16) * 32'd250_000_000;
    if (roll < 70) return $urandom_range(0, 255);
    return $urandom;
  endfunction

  // Targets: mostly a frequency that is in the searched range, or just off it.
  function automatic logic [FREQ_W-1:0] pick_target();
    int                n;
    int unsigned       roll;
    logic [FREQ_W-1:0] f;
    n    = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    roll = $urandom_range(0, 99);
    f    = (n > 0) ? shadow_freq[$urandom_range(0, n - 1)] : $urandom;
    if (roll < 40) return f;
    if (roll < 55) return roll[0] ? f + 1'b1 : f - 1'b1;
    if (roll < 65) begin
      case (roll % 4)
        0:       return '0;
        1:       return '1;
        2:       return 32'd1;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    if (roll < 80) return pick_freq();
    return $urandom;
  endfunction

  // Offer one item, wait for the handshake, then update the shadow state.
  // Valid is left high on return; the next call or the caller lowers it in
  // the same step, so it is never assigned twice per step.
  task automatic send_item(input logic                op,
                           input logic [IN_IDX_W-1:0] idx,
                           input logic [FREQ_W-1:0]   freq,
                           input logic [WORD_W-1:0]   word,
                           input logic [FREQ_W-1:0]   target,
                           input bit                  typed,
                           input match_t              want);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.entry_index <= idx;
    in_ch.entry_freq  <= freq;
    in_ch.entry_word  <= word;
    in_ch.search_freq <= target;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_LOAD) begin
      shadow_freq[idx] = freq;
      shadow_word[idx] = word;
      loads_sent++;
    end else begin
      pending_matches.push_back(typed ? want : floor_match_lookup(target));
      searches_sent++;
    end
  endtask

  // Drain all outstanding results, let a trailing load or scan finish,
  // then write entry_count.
  task automatic write_entry_count(input logic [CNT_W-1:0] count);
    in_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wdata <= count;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_count  = count;
    settings_written++;
  endtask

  task automatic note_mismatch(input string what, input match_t want, input match_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected status %0d exact %0d freq %h word %h",
               $realtime, what, want.status, want.exact, want.freq, want.word);
      $display("%0t: %s: got      status %0d exact %0d freq %h word %h",
               $realtime, what, got.status, got.exact, got.freq, got.word);
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    match_t want;
    match_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.exact, out_ch.match_freq, out_ch.match_word};
      if (pending_matches.size() == 0) begin
        note_mismatch("result with no search outstanding", NOT_FOUND, got);
      end else begin
        want = pending_matches.pop_front();
        if (want.status == STATUS_NONE) miss_hits++;
        else if (want.exact)           exact_hits++;
        else                           floor_hits++;
        if (got.status !== want.status || got.exact !== want.exact ||
            got.freq !== want.freq || got.word !== want.word) begin
          note_mismatch("search result differs", want, got);
        end
      end
    end
  end

  // Result receiver: random stalls per result, and once a long hold-off
  // while the sender keeps offering, so the block backs up into its input.
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_done == 0 && taken >= HOLD_OFF_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = HOLD_OFF_CYCLES;
      end else begin
        stall = calm_phase ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Stimulus: reset, directed rows, a full table load, then random phases
  // each under its own entry_count setting.
  initial begin
    stim_row_t        row;
    logic [CNT_W-1:0] count;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_LOAD;
    in_ch.entry_index <= '0;
    in_ch.entry_freq  <= '0;
    in_ch.entry_word  <= '0;
    in_ch.search_freq <= '0;
    shadow_count       = '0;
    calm_phase         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS_N; r++) begin
      row = DIRECTED_ROWS[r];
      case (row.kind)
        ROW_CFG: begin
          write_entry_count(row.count);
        end
        ROW_LOAD: begin
          send_item(OP_LOAD, row.idx, row.freq, row.word, '0, 1'b0, NOT_FOUND);
        end
        default: begin
          send_item(OP_SEARCH, '0, '0, '0, row.target, row.typed, row.want);
        end
      endcase
    end

    // Every slot gets written here, so any entry_count after this is safe.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(OP_LOAD, i[IN_IDX_W-1:0], pick_freq(), $urandom, $urandom, 1'b0, NOT_FOUND);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      count = (phase >= PHASES - 2) ? CNT_W'($urandom_range(0, 127))
                                    : CNT_W'(PHASE_COUNTS[phase]);
      write_entry_count(count);
      calm_phase = (phase % 4 == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 30) begin
          send_item(OP_LOAD, IN_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_freq(),
                    $urandom, $urandom, 1'b0, NOT_FOUND);
        end else begin
          send_item(OP_SEARCH, IN_IDX_W'($urandom), $urandom, $urandom, pick_target(),
                    1'b0, NOT_FOUND);
        end
      end
    end

    in_ch.valid <= 1'b0;
    calm_phase   = 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d loads and %0d searches across %0d entry_count settings",
             loads_sent, searches_sent, settings_written);
    $display("Results: %0d exact, %0d floor, %0d not found; output held off %0d cycles once",
             exact_hits, floor_hits, miss_hits, hold_off_done);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pllt_pkg.sv
rtl/core/pllt_if.sv
rtl/core/pll_table_best_match_search.sv
rtl/core/pllt_chk.sv
dv/pll_table_best_match_search_test.sv
